>>> rtl/vlfp_pkg.sv
//------------------------------------------------------------------------------
// vlfp_pkg
// Shared constants and the command type passed from the byte parser to the
// state update stage of the vision link frame parser.
//------------------------------------------------------------------------------
`default_nettype none

package vlfp_pkg;

    // framing bytes
    localparam logic [7:0] SYNC_FIRST   = 8'hAA;
    localparam logic [7:0] SYNC_SECOND  = 8'h55;
    localparam logic [7:0] TRAILER_BYTE = 8'h0D;

    // frame types
    localparam logic [7:0] TYPE_LINE    = 8'h01;
    localparam logic [7:0] TYPE_TARGET  = 8'h02;

    // class written when a target is seen before it is classified
    localparam logic [7:0] CLASS_UNSORTED = 8'hFF;

    // byte positions within a frame
    localparam logic [3:0] POS_IDLE    = 4'd0;
    localparam logic [3:0] POS_SYNC    = 4'd1;
    localparam logic [3:0] POS_FIRST   = 4'd2;
    localparam logic [3:0] POS_SUM_END = 4'd8;
    localparam logic [3:0] POS_TRAILER = 4'd10;

    // reset value of the liveness timeout
    localparam logic [15:0] TIMEOUT_RESET = 16'd150;

    // frame status codes
    localparam logic [2:0] STATUS_NONE        = 3'd0;
    localparam logic [2:0] STATUS_ACCEPTED    = 3'd1;
    localparam logic [2:0] STATUS_BAD_TRAILER = 3'd2;
    localparam logic [2:0] STATUS_BAD_SUM     = 3'd3;
    localparam logic [2:0] STATUS_BAD_TYPE    = 3'd4;

    // classified transaction handed from the parser to the update stage
    typedef struct packed {
        logic [2:0]  status;
        logic        apply_line;
        logic        apply_target;
        logic [47:0] payload;     // payload bytes 1..6, byte 1 in bits 7:0
        logic [31:0] time_ms;
    } vlfp_cmd_t;

endpackage

`default_nettype wire

>>> rtl/vlfp_front.sv
//------------------------------------------------------------------------------
// vlfp_front
// Byte framer: tracks the position in the frame, keeps the running sum and
// the frame bytes, and classifies each transaction into a command.
//------------------------------------------------------------------------------
`default_nettype none

module vlfp_front
    import vlfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic [31:0] time_ms,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output vlfp_cmd_t        cmd
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] store_reg [8];
    logic [2:0] store_idx;
    logic       store_wr;
    logic       accept;
    logic       take_byte;
    logic       at_trailer;
    logic [2:0] frame_status;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;
    assign take_byte = accept && !mode;
    assign at_trailer = (pos_reg >= POS_TRAILER);
    assign store_idx = 3'(pos_reg - POS_FIRST);

    // frame check at the trailer: trailer, then sum, then type
    always_comb
    begin
        frame_status = STATUS_NONE;
        if (!mode && at_trailer)
        begin
            if (data_byte != TRAILER_BYTE)
                frame_status = STATUS_BAD_TRAILER;
            else if (sum_reg != store_reg[7])
                frame_status = STATUS_BAD_SUM;
            else if (store_reg[0] == TYPE_LINE || store_reg[0] == TYPE_TARGET)
                frame_status = STATUS_ACCEPTED;
            else
                frame_status = STATUS_BAD_TYPE;
        end
    end

    // command to the update stage
    always_comb
    begin
        cmd.status       = frame_status;
        cmd.apply_line   = (frame_status == STATUS_ACCEPTED) && (store_reg[0] == TYPE_LINE);
        cmd.apply_target = (frame_status == STATUS_ACCEPTED) && (store_reg[0] == TYPE_TARGET);
        cmd.payload      = {store_reg[6], store_reg[5], store_reg[4],
                            store_reg[3], store_reg[2], store_reg[1]};
        cmd.time_ms      = time_ms;
    end

    // position and running sum
    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        store_wr = 1'b0;
        if (take_byte)
        begin
            if (pos_reg == POS_IDLE)
            begin
                if (data_byte == SYNC_FIRST)
                    pos_next = POS_SYNC;
            end
            else if (pos_reg == POS_SYNC)
            begin
                if (data_byte == SYNC_SECOND)
                begin
                    pos_next = POS_FIRST;
                    sum_next = 8'd0;
                end
                else
                begin
                    pos_next = POS_IDLE;
                end
            end
            else if (at_trailer)
            begin
                pos_next = POS_IDLE;
            end
            else
            begin
                store_wr = 1'b1;
                if (pos_reg <= POS_SUM_END)
                    sum_next = sum_reg + data_byte;
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_IDLE;
            sum_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // frame bytes: type, six payload bytes, sum byte
    always_ff @(posedge clk)
    begin
        if (store_wr)
            store_reg[store_idx] <= data_byte;
    end

endmodule

`default_nettype wire

>>> rtl/vlfp_queue.sv
//------------------------------------------------------------------------------
// vlfp_queue
// Two-entry command queue between the parser and the update stage, so that
// either side can stall without holding the other.
//------------------------------------------------------------------------------
`default_nettype none

module vlfp_queue
    import vlfp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire vlfp_cmd_t push_cmd,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output vlfp_cmd_t      pop_cmd
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    vlfp_cmd_t  head_reg;
    vlfp_cmd_t  tail_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = head_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // head holds the oldest entry, tail the second
    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
                head_reg <= push_cmd;
            else
                tail_reg <= push_cmd;
        end
        else if (pop && !push)
        begin
            head_reg <= tail_reg;
        end
        else if (push && pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_reg <= push_cmd;
            end
            else
            begin
                head_reg <= tail_reg;
                tail_reg <= push_cmd;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/vlfp_back.sv
//------------------------------------------------------------------------------
// vlfp_back
// Update stage: applies accepted frames to the decoded values, tracks link
// liveness and holds the result in an output register.
//------------------------------------------------------------------------------
`default_nettype none

module vlfp_back
    import vlfp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [15:0]      cfg_data,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire vlfp_cmd_t        cmd,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [2:0]            frame_status,
    output logic signed [15:0]    line_error,
    output logic signed [15:0]    line_angle,
    output logic                  line_found,
    output logic                  cross_seen,
    output logic [7:0]            target_kind,
    output logic signed [15:0]    target_x,
    output logic signed [15:0]    target_y,
    output logic [31:0]           frame_count,
    output logic                  link_alive
);

    logic [15:0] timeout_reg;
    logic [15:0] error_reg,  error_next;
    logic [15:0] angle_reg,  angle_next;
    logic        valid_reg,  valid_next;
    logic        cross_reg,  cross_next;
    logic [7:0]  class_reg,  class_next;
    logic [15:0] x_reg,      x_next;
    logic [15:0] y_reg,      y_next;
    logic [31:0] good_reg,   good_next;
    logic [31:0] last_reg,   last_next;
    logic [31:0] elapsed;
    logic        alive;
    logic        out_valid_reg;
    logic        take;

    logic [2:0]  status_out_reg;
    logic        alive_out_reg;

    assign cfg_ready = 1'b1;
    assign cmd_ready = !out_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;

    // decoded state after this transaction
    always_comb
    begin
        error_next = error_reg;
        angle_next = angle_reg;
        valid_next = valid_reg;
        cross_next = cross_reg;
        class_next = class_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        good_next  = good_reg;
        last_next  = last_reg;
        if (cmd.apply_line)
        begin
            error_next = cmd.payload[15:0];
            angle_next = cmd.payload[31:16];
            valid_next = cmd.payload[32];
            cross_next = cmd.payload[33];
            if (cmd.payload[34] && class_reg == 8'd0)
                class_next = CLASS_UNSORTED;
        end
        if (cmd.apply_target)
        begin
            class_next = cmd.payload[7:0];
            x_next     = cmd.payload[23:8];
            y_next     = cmd.payload[39:24];
        end
        if (cmd.apply_line || cmd.apply_target)
        begin
            good_next = good_reg + 32'd1;
            last_next = cmd.time_ms;
        end
    end

    // liveness against the updated state
    assign elapsed = cmd.time_ms - last_next;
    assign alive   = (good_next != 32'd0) && (elapsed < {16'd0, timeout_reg});

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg_valid)
            timeout_reg <= cfg_data;
    end

    // decoded state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_reg <= 16'd0;
            angle_reg <= 16'd0;
            valid_reg <= 1'b0;
            cross_reg <= 1'b0;
            class_reg <= 8'd0;
            x_reg     <= 16'd0;
            y_reg     <= 16'd0;
            good_reg  <= 32'd0;
            last_reg  <= 32'd0;
        end
        else if (take)
        begin
            error_reg <= error_next;
            angle_reg <= angle_next;
            valid_reg <= valid_next;
            cross_reg <= cross_next;
            class_reg <= class_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            good_reg  <= good_next;
            last_reg  <= last_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // per-transaction result fields
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_out_reg <= cmd.status;
            alive_out_reg  <= alive;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_out_reg;
    assign link_alive   = alive_out_reg;
    assign line_error   = signed'(error_reg);
    assign line_angle   = signed'(angle_reg);
    assign line_found   = valid_reg;
    assign cross_seen   = cross_reg;
    assign target_kind  = class_reg;
    assign target_x     = signed'(x_reg);
    assign target_y     = signed'(y_reg);
    assign frame_count  = good_reg;

endmodule

`default_nettype wire

>>> rtl/vision_link_frame_parser_unit.sv
//------------------------------------------------------------------------------
// vision_link_frame_parser_unit
// Parses 11-byte link frames (AA 55, type, six payload bytes, sum, 0D) and
// reports decoded line and target values with link liveness per transaction.
//------------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       in_valid/in_ready, mode, data_byte,        input
//           time_ms
//  out      out_valid/out_ready, frame_status, ...     output
//  cfg      cfg_valid/cfg_ready, cfg_data              input
//
//  one transaction per cycle while the queue is not full; commands pass the
//  queue registers, then the output register. The parser classifies a byte
//  in the cycle it is accepted; the update stage applies it in the cycle it
//  leaves the queue. Reset clears the parser, the decoded values and sets
//  the timeout to 150. A two-entry queue lets input keep flowing for two
//  transactions while the output is stalled; cfg_ready is always high.
//------------------------------------------------------------------------------
`default_nettype none

module vision_link_frame_parser_unit
    import vlfp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [15:0]      cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             mode,
    input  wire logic [7:0]       data_byte,
    input  wire logic [31:0]      time_ms,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [2:0]            frame_status,
    output logic signed [15:0]    line_error,
    output logic signed [15:0]    line_angle,
    output logic                  line_found,
    output logic                  cross_seen,
    output logic [7:0]            target_kind,
    output logic signed [15:0]    target_x,
    output logic signed [15:0]    target_y,
    output logic [31:0]           frame_count,
    output logic                  link_alive
);

    vlfp_cmd_t front_cmd;
    vlfp_cmd_t back_cmd;
    logic      front_valid;
    logic      front_ready;
    logic      back_valid;
    logic      back_ready;

    // byte framer
    vlfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .data_byte (data_byte),
        .time_ms   (time_ms),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // command queue
    vlfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    // state update and result register
    vlfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .cmd_valid    (back_valid),
        .cmd_ready    (back_ready),
        .cmd          (back_cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_status (frame_status),
        .line_error   (line_error),
        .line_angle   (line_angle),
        .line_found   (line_found),
        .cross_seen   (cross_seen),
        .target_kind  (target_kind),
        .target_x     (target_x),
        .target_y     (target_y),
        .frame_count  (frame_count),
        .link_alive   (link_alive)
    );

endmodule

`default_nettype wire
